// ----- rtl/core/modbus_slave_register_map_core_defines.svh -----
// Assertion macros for the Modbus slave register map core.
`ifndef MODBUS_SLAVE_REGISTER_MAP_CORE_DEFINES_SVH
`define MODBUS_SLAVE_REGISTER_MAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/msrm_pkg.sv -----
// Package with codes and constants for the Modbus slave register map core.
package msrm_pkg;

    localparam int NUM_POINTS_DEF = 8;
    localparam int WORD_W         = 16;
    localparam int PAYLOAD_WORDS  = 8;

    // Request operations
    localparam logic [1:0] OP_REQUEST      = 2'd0;
    localparam logic [1:0] OP_SET_DISCRETE = 2'd1;
    localparam logic [1:0] OP_SET_SENSOR   = 2'd2;

    // Function codes
    localparam logic [7:0] FC_READ_COILS     = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT     = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
    localparam logic [7:0] FC_WRITE_REGISTER = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

    // Reply status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FUNCTION = 2'd1;
    localparam logic [1:0] ST_ADDRESS  = 2'd2;
    localparam logic [1:0] ST_VALUE    = 2'd3;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;
    localparam logic [7:0]  OWN_ADDRESS_RST = 8'd1;

endpackage

// ----- rtl/core/modbus_slave_register_map_core.sv -----
// Modbus slave request handler over a small coil / register map.
// Timing: requests are accepted in IDLE and checked in CHECK; single replies and exceptions are
// registered from CHECK; register reads strobe one word per cycle from LOOP; multiple writes reply the cycle after
// their last point step. Replies cannot be stalled by the receiver.
// Busy covers the CHECK step and, for register reads and multiple writes, one LOOP step per point,
// paced by the shared point-index adder; set-discrete, set-sensor and unaddressed requests never raise busy.
`include "modbus_slave_register_map_core_defines.svh"

module modbus_slave_register_map_core
    import msrm_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        own_address_we,
    input  logic [7:0]  own_address_wdata,
    // request side
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  slave_address,
    input  logic [7:0]  function_code,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity_or_value,
    input  logic [7:0]  byte_count,
    input  logic [63:0] payload_low,
    input  logic [63:0] payload_high,
    // reply side, one cycle per strobe, no back-pressure
    output logic        reply_strobe,
    output logic [1:0]  reply_status,
    output logic [7:0]  reply_function,
    output logic [4:0]  reply_byte_count,
    output logic [15:0] reply_address,
    output logic [15:0] reply_word,
    output logic [15:0] event_total,
    output logic        last
);

    // Reset clears all coils, inputs, registers, the event counter and sets own_address to 1.

    localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int CNT_W = $clog2(NUM_POINTS + 1);
    localparam int SEL_W = $clog2(PAYLOAD_WORDS);

    // IDLE takes requests; CHECK runs the value/range checks; LOOP steps the
    // shared index adder start + i over the points of register reads and multiple writes.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_LOOP
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]              own_addr_reg;
    logic [NUM_POINTS-1:0]   coil_reg, coil_next;
    logic [NUM_POINTS-1:0]   disc_reg, disc_next;
    logic [WORD_W-1:0]       hold_reg [NUM_POINTS];
    logic [WORD_W-1:0]       sens_reg [NUM_POINTS];
    logic [15:0]             counter_reg, counter_next;

    // latched request
    logic [7:0]              fn_reg, fn_next;
    logic [15:0]             start_reg, start_next;
    logic [15:0]             qv_reg, qv_next;
    logic [7:0]              bc_reg, bc_next;
    logic [WORD_W-1:0]       pay_reg [PAYLOAD_WORDS];
    logic [WORD_W-1:0]       pay_next [PAYLOAD_WORDS];
    logic [CNT_W-1:0]        i_reg, i_next;

    // reply registers
    logic        strobe_reg, strobe_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  rfn_reg, rfn_next;
    logic [4:0]  rbc_reg, rbc_next;
    logic [15:0] raddr_reg, raddr_next;
    logic [15:0] rword_reg, rword_next;
    logic [15:0] evt_reg, evt_next;
    logic        last_reg, last_next;

    // holding register write port
    logic              hold_we;
    logic [IDX_W-1:0]  hold_waddr;
    logic [WORD_W-1:0] hold_wdata;

    // sensor write port, straight from the request side
    logic              sens_we;
    logic [IDX_W-1:0]  sens_waddr;

    logic              addr_hit;
    logic              range_bad;
    logic              start_bad;
    logic              qv_zero;
    logic [IDX_W-1:0]  rs;
    logic [IDX_W-1:0]  idx;
    logic [SEL_W-1:0]  wsel;
    logic              i_last;
    logic [NUM_POINTS-1:0] bit_src;
    logic [NUM_POINTS-1:0] bit_mask;
    logic [NUM_POINTS-1:0] bit_shift;
    logic [7:0]        coil_byte;

    assign busy = (state_reg != S_IDLE);

    assign addr_hit   = (slave_address == own_addr_reg) || (slave_address == 8'd0);
    assign sens_we    = start && !busy && (operation == OP_SET_SENSOR)
                        && (start_address < 16'(NUM_POINTS));
    assign sens_waddr = start_address[IDX_W-1:0];

    // shared check / index unit
    assign start_bad = (start_reg >= 16'(NUM_POINTS));
    assign range_bad = start_bad
                       || (({1'b0, start_reg} + {1'b0, qv_reg}) > 17'(NUM_POINTS));
    assign qv_zero   = (qv_reg == 16'd0);
    assign rs        = start_reg[IDX_W-1:0];
    assign idx       = rs + i_reg[IDX_W-1:0];
    assign wsel      = SEL_W'(i_reg);
    assign i_last    = ((16'(i_reg) + 16'd1) == qv_reg);
    assign coil_byte = pay_reg[0][7:0];

    assign bit_src   = (fn_reg == FC_READ_COILS) ? coil_reg : disc_reg;
    assign bit_shift = bit_src >> rs;

    always_comb
    begin
        for (int k = 0; k < NUM_POINTS; k++)
        begin
            bit_mask[k] = (16'(k) < qv_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        coil_next    = coil_reg;
        disc_next    = disc_reg;
        counter_next = counter_reg;
        fn_next      = fn_reg;
        start_next   = start_reg;
        qv_next      = qv_reg;
        bc_next      = bc_reg;
        pay_next     = pay_reg;
        i_next       = i_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        rfn_next     = rfn_reg;
        rbc_next     = rbc_reg;
        raddr_next   = raddr_reg;
        rword_next   = rword_reg;
        evt_next     = evt_reg;
        last_next    = last_reg;
        hold_we      = 1'b0;
        hold_waddr   = idx;
        hold_wdata   = pay_reg[wsel];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_SET_DISCRETE:
                        begin
                            disc_next = quantity_or_value[NUM_POINTS-1:0];
                        end
                        OP_REQUEST:
                        begin
                            if (addr_hit)
                            begin
                                fn_next    = function_code;
                                start_next = start_address;
                                qv_next    = quantity_or_value;
                                bc_next    = byte_count;
                                for (int k = 0; k < PAYLOAD_WORDS / 2; k++)
                                begin
                                    pay_next[k] = payload_low[k*WORD_W +: WORD_W];
                                    pay_next[k + PAYLOAD_WORDS / 2] =
                                        payload_high[k*WORD_W +: WORD_W];
                                end
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                // single OK reply by default; error and loop paths override
                strobe_next = 1'b1;
                rfn_next    = fn_reg;
                rbc_next    = 5'd0;
                raddr_next  = 16'd0;
                rword_next  = 16'd0;
                evt_next    = counter_reg;
                last_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
                i_next      = '0;

                case (fn_reg)
                    FC_READ_COILS, FC_READ_DISCRETE:
                    begin
                        if (qv_zero)
                            status_next = ST_VALUE;
                        else if (range_bad)
                            status_next = ST_ADDRESS;
                        else
                        begin
                            counter_next = counter_reg + 16'd1;
                            evt_next     = counter_reg + 16'd1;
                            rbc_next     = 5'd1;
                            rword_next   = 16'(bit_shift & bit_mask);
                        end
                    end
                    FC_READ_HOLDING, FC_READ_INPUT:
                    begin
                        if (qv_zero)
                            status_next = ST_VALUE;
                        else if (range_bad)
                            status_next = ST_ADDRESS;
                        else
                        begin
                            counter_next = counter_reg + 16'd1;
                            strobe_next  = 1'b0;
                            state_next   = S_LOOP;
                        end
                    end
                    FC_WRITE_COIL:
                    begin
                        if (start_bad)
                            status_next = ST_ADDRESS;
                        else if ((qv_reg != COIL_ON) && (qv_reg != COIL_OFF))
                            status_next = ST_VALUE;
                        else
                        begin
                            coil_next[rs] = (qv_reg == COIL_ON);
                            counter_next  = counter_reg + 16'd1;
                            evt_next      = counter_reg + 16'd1;
                            raddr_next    = start_reg;
                            rword_next    = qv_reg;
                        end
                    end
                    FC_WRITE_REGISTER:
                    begin
                        if (start_bad)
                            status_next = ST_ADDRESS;
                        else
                        begin
                            hold_we      = 1'b1;
                            hold_waddr   = rs;
                            hold_wdata   = qv_reg;
                            counter_next = counter_reg + 16'd1;
                            evt_next     = counter_reg + 16'd1;
                            raddr_next   = start_reg;
                            rword_next   = qv_reg;
                        end
                    end
                    FC_WRITE_COILS:
                    begin
                        if (qv_zero || (bc_reg != 8'd1))
                            status_next = ST_VALUE;
                        else if (range_bad)
                            status_next = ST_ADDRESS;
                        else
                        begin
                            strobe_next = 1'b0;
                            state_next  = S_LOOP;
                        end
                    end
                    FC_WRITE_REGS:
                    begin
                        if (qv_zero || ({9'd0, bc_reg} != {qv_reg, 1'b0}))
                            status_next = ST_VALUE;
                        else if (range_bad)
                            status_next = ST_ADDRESS;
                        else
                        begin
                            strobe_next = 1'b0;
                            state_next  = S_LOOP;
                        end
                    end
                    default:
                    begin
                        status_next = ST_FUNCTION;
                    end
                endcase
            end

            S_LOOP:
            begin
                i_next = i_reg + CNT_W'(1);
                if (i_last)
                    state_next = S_IDLE;

                case (fn_reg)
                    FC_READ_HOLDING, FC_READ_INPUT:
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_OK;
                        rfn_next    = fn_reg;
                        rbc_next    = 5'({qv_reg, 1'b0});
                        raddr_next  = 16'd0;
                        rword_next  = (fn_reg == FC_READ_HOLDING) ? hold_reg[idx]
                                                                  : sens_reg[idx];
                        evt_next    = counter_reg;
                        last_next   = i_last;
                    end
                    FC_WRITE_COILS, FC_WRITE_REGS:
                    begin
                        if (fn_reg == FC_WRITE_COILS)
                            coil_next[idx] = coil_byte[wsel];
                        else
                            hold_we = 1'b1;
                        if (i_last)
                        begin
                            counter_next = counter_reg + 16'd1;
                            strobe_next  = 1'b1;
                            status_next  = ST_OK;
                            rfn_next     = fn_reg;
                            rbc_next     = 5'd0;
                            raddr_next   = start_reg;
                            rword_next   = qv_reg;
                            evt_next     = counter_reg + 16'd1;
                            last_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            own_addr_reg <= OWN_ADDRESS_RST;
            coil_reg     <= '0;
            disc_reg     <= '0;
            counter_reg  <= '0;
            strobe_reg   <= 1'b0;
            i_reg        <= '0;
            for (int k = 0; k < NUM_POINTS; k++)
            begin
                hold_reg[k] <= '0;
                sens_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            coil_reg    <= coil_next;
            disc_reg    <= disc_next;
            counter_reg <= counter_next;
            strobe_reg  <= strobe_next;
            i_reg       <= i_next;
            if (own_address_we)
                own_addr_reg <= own_address_wdata;
            if (hold_we)
                hold_reg[hold_waddr] <= hold_wdata;
            if (sens_we)
                sens_reg[sens_waddr] <= quantity_or_value;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        fn_reg     <= fn_next;
        start_reg  <= start_next;
        qv_reg     <= qv_next;
        bc_reg     <= bc_next;
        pay_reg    <= pay_next;
        status_reg <= status_next;
        rfn_reg    <= rfn_next;
        rbc_reg    <= rbc_next;
        raddr_reg  <= raddr_next;
        rword_reg  <= rword_next;
        evt_reg    <= evt_next;
        last_reg   <= last_next;
    end

    assign reply_strobe     = strobe_reg;
    assign reply_status     = status_reg;
    assign reply_function   = rfn_reg;
    assign reply_byte_count = rbc_reg;
    assign reply_address    = raddr_reg;
    assign reply_word       = rword_reg;
    assign event_total      = evt_reg;
    assign last             = last_reg;

    // A request for this slave always enters the check step.
    `MSRM_ASSERT_NEXT(a_req_enters_check,
        start && !busy && (operation == OP_REQUEST) && addr_hit,
        state_reg == S_CHECK, "addressed request not taken")
    // A non-final reply means more results are still coming.
    `MSRM_ASSERT_NOW(a_more_follows, reply_strobe && !last,
        busy, "non-final reply with sequencer idle")
    // Exceptions are single results.
    `MSRM_ASSERT_NOW(a_exc_single, reply_strobe && (reply_status != ST_OK),
        last, "exception reply not marked last")
    // Exceptions never bump the event counter.
    `MSRM_ASSERT_NOW(a_exc_no_count, reply_strobe && (reply_status != ST_OK),
        event_total == counter_reg, "exception changed event counter")

endmodule
